// File: hw/rtl/vehicle_maneuver_sequencer_defines.svh
`ifndef VEHICLE_MANEUVER_SEQUENCER_DEFINES_SVH
`define VEHICLE_MANEUVER_SEQUENCER_DEFINES_SVH

// same-cycle implication on i_clk, off during reset
`define VMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vms assertion failed");

// next-cycle implication on i_clk, off during reset
`define VMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vms assertion failed");

`endif

// File: hw/rtl/vms_pkg.sv
`default_nettype none

package vms_pkg;

    typedef enum logic [1:0] {
        REG_DRIVE_SPEED    = 2'd0,
        REG_STOP_THRESHOLD = 2'd1,
        REG_TURN_STEER     = 2'd2,
        REG_PARK_STEER     = 2'd3
    } t_reg_idx;

    localparam logic [3:0] BTN_IDX_FORWARD  = 4'd0;
    localparam logic [3:0] BTN_IDX_STOP     = 4'd1;
    localparam logic [3:0] BTN_IDX_PARK     = 4'd2;
    localparam logic [3:0] BTN_IDX_BACKWARD = 4'd3;
    localparam logic [3:0] BTN_IDX_PARALLEL = 4'd12;
    localparam logic [3:0] BTN_IDX_TURNING  = 4'd14;

    localparam logic [3:0] PARK_LAST = 4'd5;
    localparam logic [3:0] TURN_LAST = 4'd9;

    typedef enum logic [2:0] {
        BTN_NONE,
        BTN_FORWARD,
        BTN_STOP,
        BTN_PARK,
        BTN_BACKWARD,
        BTN_PARALLEL,
        BTN_TURNING
    } t_btn;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FORWARD,
        MODE_STOP,
        MODE_BACKWARD,
        MODE_PARALLEL,
        MODE_TURNING,
        MODE_PARK
    } t_mode;

    typedef enum logic [2:0] {
        MAN_NONE     = 3'd0,
        MAN_FORWARD  = 3'd1,
        MAN_BACKWARD = 3'd2,
        MAN_PARALLEL = 3'd3,
        MAN_TURNING  = 3'd4
    } t_man;

    typedef enum logic [1:0] {
        DIR_ZERO,
        DIR_POS,
        DIR_NEG
    } t_dir;

    typedef enum logic [1:0] {
        KIND_STOP,
        KIND_FWD,
        KIND_BACK
    } t_kind;

    typedef struct packed {
        t_dir       spd;
        t_dir       str;
        t_kind      kind;
        logic [3:0] span;
        logic       upd;
    } t_stage;

    typedef struct packed {
        logic               tick;
        t_btn               btn;
        logic               pressed;
        logic signed [31:0] enc;
        logic signed [15:0] spd;
    } t_item;

    typedef struct packed {
        logic [11:0] drive_speed;
        logic [9:0]  stop_threshold;
        logic [6:0]  turn_steer;
        logic [6:0]  park_steer;
    } t_cfg;

    typedef struct packed {
        logic pop;
        logic pop_tick;
    } t_back_stat;

    function automatic t_stage f_turn_stage(input logic [3:0] s);
        t_stage e;
        case (s)
            4'd0:    e = '{DIR_POS,  DIR_POS,  KIND_FWD,  4'd10, 1'b0};
            4'd1:    e = '{DIR_ZERO, DIR_POS,  KIND_STOP, 4'd0,  1'b1};
            4'd2:    e = '{DIR_NEG,  DIR_NEG,  KIND_BACK, 4'd2,  1'b0};
            4'd3:    e = '{DIR_ZERO, DIR_NEG,  KIND_STOP, 4'd0,  1'b1};
            4'd4:    e = '{DIR_POS,  DIR_POS,  KIND_FWD,  4'd2,  1'b0};
            4'd5:    e = '{DIR_ZERO, DIR_POS,  KIND_STOP, 4'd0,  1'b1};
            4'd6:    e = '{DIR_NEG,  DIR_NEG,  KIND_BACK, 4'd2,  1'b0};
            4'd7:    e = '{DIR_ZERO, DIR_NEG,  KIND_STOP, 4'd0,  1'b1};
            4'd8:    e = '{DIR_POS,  DIR_POS,  KIND_FWD,  4'd5,  1'b0};
            default: e = '{DIR_ZERO, DIR_ZERO, KIND_STOP, 4'd0,  1'b0};
        endcase
        return e;
    endfunction

    function automatic t_stage f_park_stage(input logic [3:0] s);
        t_stage e;
        case (s)
            4'd0:    e = '{DIR_NEG,  DIR_NEG,  KIND_BACK, 4'd10, 1'b1};
            4'd1:    e = '{DIR_ZERO, DIR_NEG,  KIND_STOP, 4'd0,  1'b1};
            4'd2:    e = '{DIR_NEG,  DIR_POS,  KIND_BACK, 4'd2,  1'b0};
            4'd3:    e = '{DIR_ZERO, DIR_POS,  KIND_STOP, 4'd0,  1'b1};
            4'd4:    e = '{DIR_POS,  DIR_NEG,  KIND_FWD,  4'd1,  1'b0};
            default: e = '{DIR_ZERO, DIR_ZERO, KIND_STOP, 4'd0,  1'b0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vms_front.sv
`default_nettype none

module vms_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [3:0]           i_button_index,
    input  logic                 i_pressed,
    input  logic signed [31:0]   i_encoder_count,
    input  logic signed [15:0]   i_measured_speed,
    output logic                 o_head_valid,
    output vms_pkg::t_item       o_head,
    input  logic                 i_pop
);
    import vms_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    t_btn              w_btn;
    t_item             w_item;
    logic              w_push;

    always_comb begin
        case (i_button_index)
            BTN_IDX_FORWARD:  w_btn = BTN_FORWARD;
            BTN_IDX_STOP:     w_btn = BTN_STOP;
            BTN_IDX_PARK:     w_btn = BTN_PARK;
            BTN_IDX_BACKWARD: w_btn = BTN_BACKWARD;
            BTN_IDX_PARALLEL: w_btn = BTN_PARALLEL;
            BTN_IDX_TURNING:  w_btn = BTN_TURNING;
            default:          w_btn = BTN_NONE;
        endcase
    end

    assign w_item = '{tick: i_operation, btn: w_btn, pressed: i_pressed,
                      enc: i_encoder_count, spd: i_measured_speed};

    assign o_in_ready   = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign w_push       = i_in_valid && o_in_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vms_back.sv
`default_nettype none

module vms_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vms_pkg::t_cfg        i_cfg,
    input  logic                 i_head_valid,
    input  vms_pkg::t_item       i_head,
    output logic                 o_pop,
    output vms_pkg::t_back_stat  o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [12:0]   o_speed_command,
    output logic signed [7:0]    o_steer_command,
    output logic                 o_park_brake,
    output logic [2:0]           o_maneuver_code
);
    import vms_pkg::*;

    t_mode              r_mode, n_mode;
    logic [3:0]         r_stage, n_stage;
    logic signed [31:0] r_ref, n_ref;
    logic signed [31:0] r_last, n_last;
    logic signed [12:0] r_speed, n_speed;
    logic signed [7:0]  r_steer, n_steer;
    logic               r_park, n_park;
    t_man               r_man, n_man;

    logic               r_out_valid;
    logic signed [12:0] r_out_speed;
    logic signed [7:0]  r_out_steer;
    logic               r_out_park;
    t_man               r_out_man;

    logic               w_turn;
    t_stage             w_stage;
    logic [3:0]         w_last_idx;
    logic               w_in_range;
    logic [6:0]         w_steer_mag;
    logic signed [12:0] w_drive_pos, w_drive_neg, w_seq_speed;
    logic signed [7:0]  w_steer_pos, w_steer_neg, w_seq_steer;
    logic signed [33:0] w_c34, w_r34, w_d34;
    logic [16:0]        w_spd_ext, w_mag;
    logic               w_adv;
    logic               w_load;

    assign w_turn      = (r_mode == MODE_TURNING);
    assign w_stage     = w_turn ? f_turn_stage(r_stage) : f_park_stage(r_stage);
    assign w_last_idx  = w_turn ? TURN_LAST : PARK_LAST;
    assign w_in_range  = (r_stage <= w_last_idx);
    assign w_steer_mag = w_turn ? i_cfg.turn_steer : i_cfg.park_steer;

    assign w_drive_pos = {1'b0, i_cfg.drive_speed};
    assign w_drive_neg = 13'sd0 - w_drive_pos;
    assign w_steer_pos = {1'b0, w_steer_mag};
    assign w_steer_neg = 8'sd0 - w_steer_pos;

    always_comb begin
        case (w_stage.spd)
            DIR_POS: w_seq_speed = w_drive_pos;
            DIR_NEG: w_seq_speed = w_drive_neg;
            default: w_seq_speed = '0;
        endcase
        case (w_stage.str)
            DIR_POS: w_seq_steer = w_steer_pos;
            DIR_NEG: w_seq_steer = w_steer_neg;
            default: w_seq_steer = '0;
        endcase
    end

    assign w_c34     = {{2{i_head.enc[31]}}, i_head.enc};
    assign w_r34     = {{2{r_ref[31]}}, r_ref};
    assign w_d34     = {30'd0, w_stage.span};
    assign w_spd_ext = {i_head.spd[15], i_head.spd};
    assign w_mag     = i_head.spd[15] ? (17'd0 - w_spd_ext) : w_spd_ext;

    always_comb begin
        case (w_stage.kind)
            KIND_FWD:  w_adv = (w_c34 > (w_r34 + w_d34));
            KIND_BACK: w_adv = (w_c34 < (w_r34 - w_d34));
            default:   w_adv = (w_mag < {7'd0, i_cfg.stop_threshold});
        endcase
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_stage = r_stage;
        n_ref   = r_ref;
        n_last  = r_last;
        n_speed = r_speed;
        n_steer = r_steer;
        n_park  = r_park;
        n_man   = r_man;
        if (o_pop) begin
            if (i_head.tick) begin
                n_last = i_head.enc;
                case (r_mode)
                    MODE_FORWARD: begin
                        n_park  = 1'b0;
                        n_speed = w_drive_pos;
                        n_steer = '0;
                        n_mode  = MODE_IDLE;
                    end
                    MODE_STOP: begin
                        n_park  = 1'b0;
                        n_speed = '0;
                        n_steer = '0;
                        n_mode  = MODE_IDLE;
                    end
                    MODE_BACKWARD: begin
                        n_park  = 1'b0;
                        n_speed = w_drive_neg;
                        n_steer = '0;
                        n_mode  = MODE_IDLE;
                    end
                    MODE_PARALLEL, MODE_TURNING: begin
                        n_park = 1'b0;
                        if (w_in_range) begin
                            n_speed = w_seq_speed;
                            n_steer = w_seq_steer;
                            if (w_adv) begin
                                if (r_stage == w_last_idx) begin
                                    n_man  = MAN_NONE;
                                    n_mode = MODE_IDLE;
                                end else begin
                                    if (w_stage.upd) begin
                                        n_ref = i_head.enc;
                                    end
                                    n_stage = r_stage + 4'd1;
                                end
                            end
                        end
                    end
                    MODE_PARK: begin
                        n_park = 1'b1;
                        n_mode = MODE_IDLE;
                    end
                    default: ;
                endcase
            end else begin
                case (i_head.btn)
                    BTN_FORWARD: begin
                        n_man = MAN_FORWARD;
                        if (i_head.pressed && r_mode == MODE_IDLE) begin
                            n_mode = MODE_FORWARD;
                        end
                    end
                    BTN_STOP: begin
                        n_man = MAN_NONE;
                        if (i_head.pressed) begin
                            n_mode = MODE_STOP;
                        end
                    end
                    BTN_PARK: begin
                        n_man = MAN_NONE;
                        if (i_head.pressed && r_mode == MODE_IDLE) begin
                            n_mode = MODE_PARK;
                        end
                    end
                    BTN_BACKWARD: begin
                        n_man = MAN_BACKWARD;
                        if (i_head.pressed && r_mode == MODE_IDLE) begin
                            n_mode = MODE_BACKWARD;
                        end
                    end
                    BTN_PARALLEL: begin
                        n_man = MAN_PARALLEL;
                        if (i_head.pressed && r_mode == MODE_IDLE) begin
                            n_ref   = r_last;
                            n_stage = '0;
                            n_mode  = MODE_PARALLEL;
                        end
                    end
                    BTN_TURNING: begin
                        n_man = MAN_TURNING;
                        if (i_head.pressed && r_mode == MODE_IDLE) begin
                            n_ref   = r_last;
                            n_stage = '0;
                            n_mode  = MODE_TURNING;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // handshake and result load
    always_comb begin
        o_pop           = i_head_valid && (!i_head.tick || !r_out_valid || i_out_ready);
        w_load          = o_pop && i_head.tick;
        o_stat.pop      = o_pop;
        o_stat.pop_tick = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_stage     <= '0;
            r_ref       <= '0;
            r_last      <= '0;
            r_speed     <= '0;
            r_steer     <= '0;
            r_park      <= 1'b0;
            r_man       <= MAN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_stage     <= n_stage;
            r_ref       <= n_ref;
            r_last      <= n_last;
            r_speed     <= n_speed;
            r_steer     <= n_steer;
            r_park      <= n_park;
            r_man       <= n_man;
            r_out_valid <= w_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_speed <= n_speed;
            r_out_steer <= n_steer;
            r_out_park  <= n_park;
            r_out_man   <= n_man;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_command = r_out_speed;
    assign o_steer_command = r_out_steer;
    assign o_park_brake    = r_out_park;
    assign o_maneuver_code = r_out_man;

endmodule

`default_nettype wire

// File: hw/rtl/vehicle_maneuver_sequencer.sv
// Vehicle maneuver sequencer. Button items pick forward, reverse, stop, park brake, or
// the parallel-parking and turning sequences; each tick item gives exactly one result
// with the latched speed, steering, park and maneuver commands. The block takes one
// item per cycle while its queue has room: the input side only decodes and writes an
// item queue of QUEUE_DEPTH entries, and the executor retires one queued item per
// cycle, stalling only a tick whose result would overwrite an output register not yet
// taken. A result is valid in the cycle after its tick pops. Configure the registers
// over the APB port (byte addresses 0, 4, 8, 12) only while no item is in flight.
`default_nettype none

`include "vehicle_maneuver_sequencer_defines.svh"

module vehicle_maneuver_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [3:0]           i_button_index,
    input  logic                 i_pressed,
    input  logic signed [31:0]   i_encoder_count,
    input  logic signed [15:0]   i_measured_speed,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [12:0]   o_speed_command,
    output logic signed [7:0]    o_steer_command,
    output logic                 o_park_brake,
    output logic [2:0]           o_maneuver_code
);
    import vms_pkg::*;

    t_cfg        r_cfg;
    t_reg_idx    w_idx;
    logic        w_wr;
    logic        w_head_valid;
    t_item       w_head;
    logic        w_pop;
    t_back_stat  w_stat;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_speed    <= 12'd2000;
            r_cfg.stop_threshold <= 10'd10;
            r_cfg.turn_steer     <= 7'd45;
            r_cfg.park_steer     <= 7'd40;
        end else if (w_wr) begin
            case (w_idx)
                REG_DRIVE_SPEED:    r_cfg.drive_speed    <= pwdata[11:0];
                REG_STOP_THRESHOLD: r_cfg.stop_threshold <= pwdata[9:0];
                REG_TURN_STEER:     r_cfg.turn_steer     <= pwdata[6:0];
                REG_PARK_STEER:     r_cfg.park_steer     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DRIVE_SPEED:    prdata = {20'd0, r_cfg.drive_speed};
            REG_STOP_THRESHOLD: prdata = {22'd0, r_cfg.stop_threshold};
            REG_TURN_STEER:     prdata = {25'd0, r_cfg.turn_steer};
            REG_PARK_STEER:     prdata = {25'd0, r_cfg.park_steer};
            default:            prdata = '0;
        endcase
    end

    vms_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_button_index  (i_button_index),
        .i_pressed       (i_pressed),
        .i_encoder_count (i_encoder_count),
        .i_measured_speed(i_measured_speed),
        .o_head_valid    (w_head_valid),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    vms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_stat         (w_stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_speed_command(o_speed_command),
        .o_steer_command(o_steer_command),
        .o_park_brake   (o_park_brake),
        .o_maneuver_code(o_maneuver_code)
    );

    `VMS_ASSERT_NEXT(a_tick_gives_result, w_stat.pop_tick, o_out_valid)
    `VMS_ASSERT_NEXT(a_taken_result_clears, !w_stat.pop_tick && o_out_valid && i_out_ready, !o_out_valid)
    `VMS_ASSERT_SAME(a_pop_needs_head, w_stat.pop, w_head_valid)
    `VMS_ASSERT_SAME(a_code_in_range, o_out_valid, o_maneuver_code <= 3'd4)

endmodule

`default_nettype wire

// File: tb/sv/vehicle_maneuver_sequencer_tb.sv
`timescale 1ns / 100ps

module vehicle_maneuver_sequencer_tb;
    import vms_pkg::*;

    localparam logic   OP_BUTTON            = 1'b0;
    localparam logic   OP_TICK              = 1'b1;
    localparam int     RAND_ITEMS_PER_PHASE = 475;
    localparam int     SETTLE_CYCLES        = 10;
    localparam int     CYCLE_LIMIT          = 500000;
    localparam int     MAX_REPORTS          = 10;
    localparam longint ENC_MAX              = 64'sd2147483647;
    localparam longint ENC_MIN              = -64'sd2147483648;

    typedef struct packed {
        logic signed [12:0] speed;
        logic signed [7:0]  steer;
        logic               park;
        logic [2:0]         man;
    } t_cmd;

    typedef struct packed {
        logic               op;
        logic [3:0]         btn;
        logic               pr;
        logic signed [31:0] enc;
        logic signed [15:0] spd;
        logic               typed;
        t_cmd               want;
    } t_stim;

    typedef struct packed {
        int    spd;
        int    str;
        t_kind kind;
        int    span;
        logic  upd;
    } t_leg;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               in_op = OP_BUTTON;
    logic [3:0]         in_btn = '0;
    logic               in_pressed = 1'b0;
    logic signed [31:0] in_enc = '0;
    logic signed [15:0] in_spd = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [12:0] speed_cmd;
    logic signed [7:0]  steer_cmd;
    logic               park_cmd;
    logic [2:0]         man_cmd;

    t_mode              p_mode;
    logic [3:0]         p_stage;
    logic signed [31:0] p_ref;
    logic signed [31:0] p_last;
    logic signed [12:0] p_speed;
    logic signed [7:0]  p_steer;
    logic               p_park;
    t_man               p_man;
    logic [11:0]        cfg_drive;
    logic [9:0]         cfg_thr;
    logic [6:0]         cfg_turn;
    logic [6:0]         cfg_park;

    t_cmd pending_cmds[$];
    t_cmd got;
    t_cmd want;
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   stall_left = 0;

    vehicle_maneuver_sequencer u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (in_op),
        .i_button_index   (in_btn),
        .i_pressed        (in_pressed),
        .i_encoder_count  (in_enc),
        .i_measured_speed (in_spd),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_speed_command  (speed_cmd),
        .o_steer_command  (steer_cmd),
        .o_park_brake     (park_cmd),
        .o_maneuver_code  (man_cmd)
    );

    always #10 clk = ~clk;

    function automatic t_leg leg_of(input t_mode m, input logic [3:0] st);
        t_leg lg;
        lg = '{0, 0, KIND_STOP, 0, 1'b0};
        if (m == MODE_PARALLEL) begin
            case (st)
                4'd0: lg = '{-1, -1, KIND_BACK, 10, 1'b1};
                4'd1: lg = '{ 0, -1, KIND_STOP,  0, 1'b1};
                4'd2: lg = '{-1,  1, KIND_BACK,  2, 1'b0};
                4'd3: lg = '{ 0,  1, KIND_STOP,  0, 1'b1};
                4'd4: lg = '{ 1, -1, KIND_FWD,   1, 1'b0};
                default: ;
            endcase
        end else begin
            case (st)
                4'd0: lg = '{ 1,  1, KIND_FWD,  10, 1'b0};
                4'd1: lg = '{ 0,  1, KIND_STOP,  0, 1'b1};
                4'd2: lg = '{-1, -1, KIND_BACK,  2, 1'b0};
                4'd3: lg = '{ 0, -1, KIND_STOP,  0, 1'b1};
                4'd4: lg = '{ 1,  1, KIND_FWD,   2, 1'b0};
                4'd5: lg = '{ 0,  1, KIND_STOP,  0, 1'b1};
                4'd6: lg = '{-1, -1, KIND_BACK,  2, 1'b0};
                4'd7: lg = '{ 0, -1, KIND_STOP,  0, 1'b1};
                4'd8: lg = '{ 1,  1, KIND_FWD,   5, 1'b0};
                default: ;
            endcase
        end
        return lg;
    endfunction

    function automatic void reset_state();
        p_mode = MODE_IDLE;
        p_stage = '0;
        p_ref = '0;
        p_last = '0;
        p_speed = '0;
        p_steer = '0;
        p_park = 1'b0;
        p_man = MAN_NONE;
        cfg_drive = 12'd2000;
        cfg_thr = 10'd10;
        cfg_turn = 7'd45;
        cfg_park = 7'd40;
    endfunction

    function automatic void latch_button(input logic [3:0] b, input logic pr);
        case (b)
            BTN_IDX_FORWARD: begin
                p_man = MAN_FORWARD;
                if (pr && p_mode == MODE_IDLE) p_mode = MODE_FORWARD;
            end
            BTN_IDX_STOP: begin
                p_man = MAN_NONE;
                if (pr) p_mode = MODE_STOP;
            end
            BTN_IDX_PARK: begin
                p_man = MAN_NONE;
                if (pr && p_mode == MODE_IDLE) p_mode = MODE_PARK;
            end
            BTN_IDX_BACKWARD: begin
                p_man = MAN_BACKWARD;
                if (pr && p_mode == MODE_IDLE) p_mode = MODE_BACKWARD;
            end
            BTN_IDX_PARALLEL, BTN_IDX_TURNING: begin
                p_man = (b == BTN_IDX_PARALLEL) ? MAN_PARALLEL : MAN_TURNING;
                if (pr && p_mode == MODE_IDLE) begin
                    p_ref = p_last;
                    p_stage = '0;
                    p_mode = (b == BTN_IDX_PARALLEL) ? MODE_PARALLEL : MODE_TURNING;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void latch_tick(input logic signed [31:0] enc,
                                       input logic signed [15:0] spd);
        t_leg       lg;
        logic [3:0] last;
        logic [6:0] steer_mag;
        logic       adv;
        longint     c;
        longint     r;
        int         mag;
        p_last = enc;
        case (p_mode)
            MODE_FORWARD: begin
                p_park = 1'b0;
                p_speed = 13'(int'(cfg_drive));
                p_steer = '0;
                p_mode = MODE_IDLE;
            end
            MODE_STOP: begin
                p_park = 1'b0;
                p_speed = '0;
                p_steer = '0;
                p_mode = MODE_IDLE;
            end
            MODE_BACKWARD: begin
                p_park = 1'b0;
                p_speed = 13'(-int'(cfg_drive));
                p_steer = '0;
                p_mode = MODE_IDLE;
            end
            MODE_PARK: begin
                p_park = 1'b1;
                p_mode = MODE_IDLE;
            end
            MODE_PARALLEL, MODE_TURNING: begin
                p_park = 1'b0;
                last = (p_mode == MODE_PARALLEL) ? PARK_LAST : TURN_LAST;
                steer_mag = (p_mode == MODE_PARALLEL) ? cfg_park : cfg_turn;
                if (p_stage <= last) begin
                    lg = leg_of(p_mode, p_stage);
                    p_speed = 13'(lg.spd * int'(cfg_drive));
                    p_steer = 8'(lg.str * int'(steer_mag));
                    c = longint'(p_last);
                    r = longint'(p_ref);
                    mag = int'(spd);
                    if (mag < 0) mag = -mag;
                    case (lg.kind)
                        KIND_STOP: adv = mag < int'(cfg_thr);
                        KIND_FWD:  adv = c > r + lg.span;
                        default:   adv = c < r - lg.span;
                    endcase
                    if (adv) begin
                        if (p_stage == last) begin
                            p_man = MAN_NONE;
                            p_mode = MODE_IDLE;
                        end else begin
                            if (lg.upd) p_ref = p_last;
                            p_stage = p_stage + 4'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_stim btn_row(input logic [3:0] b, input logic pr);
        t_stim s;
        s = '0;
        s.op = OP_BUTTON;
        s.btn = b;
        s.pr = pr;
        return s;
    endfunction

    function automatic t_stim tick_row(input logic signed [31:0] e,
                                       input logic signed [15:0] v);
        t_stim s;
        s = '0;
        s.op = OP_TICK;
        s.enc = e;
        s.spd = v;
        return s;
    endfunction

    function automatic t_stim tick_chk(input logic signed [31:0] e,
                                       input logic signed [15:0] v, input t_cmd w);
        t_stim s;
        s = tick_row(e, v);
        s.typed = 1'b1;
        s.want = w;
        return s;
    endfunction

    function automatic t_stim next_random();
        t_stim  s;
        t_leg   lg;
        longint e;
        int     pick;
        int     mag;
        s = '0;
        s.op = OP_TICK;
        s.btn = 4'($urandom);
        s.pr = 1'($urandom);
        s.enc = 32'($urandom);
        s.spd = 16'($urandom);
        pick = int'($urandom_range(0, 99));
        if (p_mode == MODE_PARALLEL || p_mode == MODE_TURNING) begin
            if (pick < 3) begin
                s.op = OP_BUTTON;
                s.btn = BTN_IDX_STOP;
                s.pr = 1'b1;
            end else if (pick < 9) begin
                s.op = OP_BUTTON;
            end else if (pick >= 13) begin
                // steer the sample toward the exit condition of the current stage
                lg = leg_of(p_mode, p_stage);
                if (lg.kind == KIND_STOP)
                    mag = int'($urandom_range(0, 32'(cfg_thr) + 2));
                else
                    mag = int'($urandom_range(0, 40));
                s.spd = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
                case (lg.kind)
                    KIND_FWD:
                        e = longint'(p_ref) + lg.span + int'($urandom_range(0, 4)) - 1;
                    KIND_BACK:
                        e = longint'(p_ref) - lg.span - int'($urandom_range(0, 4)) + 1;
                    default:
                        e = longint'(p_last) + int'($urandom_range(0, 6)) - 3;
                endcase
                if (e > ENC_MAX) e = ENC_MAX;
                if (e < ENC_MIN) e = ENC_MIN;
                s.enc = 32'(e);
            end
        end else if (p_mode == MODE_IDLE) begin
            if (pick < 40) begin
                s.op = OP_BUTTON;
                s.btn = (pick < 20) ? BTN_IDX_PARALLEL : BTN_IDX_TURNING;
                s.pr = 1'b1;
            end else if (pick < 56) begin
                s.op = OP_BUTTON;
                s.pr = 1'b1;
                case ($urandom_range(0, 3))
                    0: s.btn = BTN_IDX_FORWARD;
                    1: s.btn = BTN_IDX_STOP;
                    2: s.btn = BTN_IDX_PARK;
                    default: s.btn = BTN_IDX_BACKWARD;
                endcase
            end else if (pick < 66) begin
                s.op = OP_BUTTON;
            end else if (pick < 82) begin
                s.enc = 32'(int'($urandom_range(0, 200)) - 100);
            end
        end else if (pick < 20) begin
            s.op = OP_BUTTON;
        end
        return s;
    endfunction

    task automatic send_item(input t_stim s);
        t_cmd c;
        in_valid = 1'b1;
        in_op = s.op;
        in_btn = s.btn;
        in_pressed = s.pr;
        in_enc = s.enc;
        in_spd = s.spd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (s.op == OP_TICK) begin
            latch_tick(s.enc, s.spd);
            if (s.typed) begin
                c = s.want;
            end else begin
                c = '{p_speed, p_steer, p_park, p_man};
            end
            pending_cmds.push_back(c);
        end else begin
            latch_button(s.btn, s.pr);
        end
        @(negedge clk);
    endtask

    task automatic idle_gap();
        if (int'($urandom_range(0, 99)) < gap_pct) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_DRIVE_SPEED:    cfg_drive = 12'(val);
            REG_STOP_THRESHOLD: cfg_thr = 10'(val);
            REG_TURN_STEER:     cfg_turn = 7'(val);
            default:            cfg_park = 7'(val);
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
        end else if (int'($urandom_range(0, 99)) < stall_pct) begin
            stall_left = int'($urandom_range(1, 17)) - 1;
            out_ready = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got = '{speed_cmd, steer_cmd, park_cmd, man_cmd};
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: speed %0d steer %0d park %0b man %0d",
                             got.speed, got.steer, got.park, got.man);
            end else begin
                want = pending_cmds.pop_front();
                if (got.speed !== want.speed || got.steer !== want.steer ||
                    got.park !== want.park || got.man !== want.man) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected speed %0d steer %0d park %0b ",
                                  "man %0d, got speed %0d steer %0d park %0b man %0d"},
                                 want.speed, want.steer, want.park, want.man,
                                 got.speed, got.steer, got.park, got.man);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("vehicle_maneuver_sequencer_tb: errors");
            $finish;
        end
    end

    initial begin
        t_stim       plan[$];
        t_stim       s;
        int          n;
        int unsigned dv;
        int unsigned th;
        int unsigned ts;
        int unsigned ps;
        reset_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        plan.push_back(tick_chk(32'sd0, 16'sd0, '{13'sd0, 8'sd0, 1'b0, MAN_NONE}));
        plan.push_back(btn_row(BTN_IDX_FORWARD, 1'b1));
        plan.push_back(tick_chk(32'sd5, 16'sd100, '{13'sd2000, 8'sd0, 1'b0, MAN_FORWARD}));
        plan.push_back(btn_row(BTN_IDX_BACKWARD, 1'b1));
        plan.push_back(tick_chk(32'sd6, 16'sd0, '{-13'sd2000, 8'sd0, 1'b0, MAN_BACKWARD}));
        plan.push_back(btn_row(BTN_IDX_PARK, 1'b1));
        plan.push_back(tick_chk(32'sd7, 16'sd0, '{-13'sd2000, 8'sd0, 1'b1, MAN_NONE}));
        plan.push_back(btn_row(BTN_IDX_STOP, 1'b1));
        plan.push_back(tick_chk(32'sd8, 16'sd0, '{13'sd0, 8'sd0, 1'b0, MAN_NONE}));
        plan.push_back(btn_row(BTN_IDX_FORWARD, 1'b0));
        plan.push_back(btn_row(4'd7, 1'b1));
        plan.push_back(tick_chk(32'sh7FFF_FFFF, 16'sh7FFF,
                                '{13'sd0, 8'sd0, 1'b0, MAN_FORWARD}));
        plan.push_back(btn_row(BTN_IDX_PARALLEL, 1'b1));
        plan.push_back(tick_row(32'sh8000_0000, 16'sh8000));
        plan.push_back(tick_row(32'sh8000_0000, 16'sd0));
        plan.push_back(tick_row(32'sh8000_0000, 16'sd0));
        plan.push_back(btn_row(BTN_IDX_TURNING, 1'b1));
        plan.push_back(btn_row(BTN_IDX_STOP, 1'b1));
        plan.push_back(tick_chk(32'sd0, 16'sd0, '{13'sd0, 8'sd0, 1'b0, MAN_NONE}));
        plan.push_back(btn_row(BTN_IDX_TURNING, 1'b1));
        plan.push_back(tick_row(32'sh7FFF_FFFF, 16'sd5));
        plan.push_back(btn_row(BTN_IDX_TURNING, 1'b0));
        plan.push_back(tick_row(32'sd0, -16'sd9));
        plan.push_back(tick_row(32'sh7FFF_FFFF, 16'sh8000));
        plan.push_back(btn_row(BTN_IDX_STOP, 1'b1));

        gap_pct = 10;
        stall_pct = 5;
        foreach (plan[i]) begin
            idle_gap();
            send_item(plan[i]);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    dv = 4000; th = 1000; ts = 100; ps = 100;
                    gap_pct = 0; stall_pct = 8;
                end
                1: begin
                    dv = 0; th = 0; ts = 0; ps = 0;
                    gap_pct = 20; stall_pct = 0;
                end
                2: begin
                    dv = $urandom_range(0, 4000); th = $urandom_range(0, 1000);
                    ts = $urandom_range(0, 100); ps = $urandom_range(0, 100);
                    gap_pct = 15; stall_pct = 6;
                end
                default: begin
                    dv = 2000; th = 10; ts = 45; ps = 40;
                    gap_pct = 0; stall_pct = 0;
                end
            endcase
            write_reg(REG_DRIVE_SPEED, dv);
            write_reg(REG_STOP_THRESHOLD, th);
            write_reg(REG_TURN_STEER, ts);
            write_reg(REG_PARK_STEER, ps);
            n = 0;
            while (n < RAND_ITEMS_PER_PHASE) begin
                // hold off until every result is back
                if (ph == 2 && n > 0 && n % 150 == 0) drain();
                s = next_random();
                if (s.op == OP_TICK || s.btn inside {BTN_IDX_FORWARD, BTN_IDX_STOP,
                        BTN_IDX_PARK, BTN_IDX_BACKWARD, BTN_IDX_PARALLEL, BTN_IDX_TURNING})
                    n++;
                idle_gap();
                send_item(s);
            end
        end

        drain();
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("vehicle_maneuver_sequencer_tb: clean");
        end else begin
            $display("vehicle_maneuver_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
